// ===== src/tdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdd_pkg: shared types and constants of the task dependency dispatcher
// Word layouts, status codes, operation codes and table sizes.
// ----------------------------------------------------------------------------
package tdd_pkg;

	localparam int LAUNCHES  = 256;
	localparam int EDGES     = 1024;
	localparam int TASK_BITS = 16;
	localparam int LID_W     = $clog2(LAUNCHES);
	localparam int EID_W     = $clog2(EDGES);
	localparam int ELNK_W    = $clog2(EDGES + 1);
	localparam int LCNT_W    = $clog2(LAUNCHES + 1);
	localparam int OPEN_W    = 9;
	localparam logic [OPEN_W-1:0] OPEN_MAX = 9'd511;

	localparam logic [1:0] OP_SUBMIT = 2'd0;
	localparam logic [1:0] OP_FETCH  = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic [2:0] ST_TAKEN   = 3'd0;
	localparam logic [2:0] ST_CREATED = 3'd1;
	localparam logic [2:0] ST_ISSUED  = 3'd2;
	localparam logic [2:0] ST_NONE    = 3'd3;
	localparam logic [2:0] ST_COUNTED = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;
	localparam logic [2:0] ST_REFUSED = 3'd6;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] task_count;
		logic        has_dependency;
		logic [7:0]  dependency_id;
		logic        last_of_submission;
		logic [7:0]  finished_launch;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  launch_id;
		logic [15:0] task_index;
		logic [15:0] launch_task_count;
		logic        all_idle;
	} rsp_t;

endpackage
`default_nettype wire

// ===== src/tdd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdd_front: command intake
// Registers one command word and hands it to the engine through a
// two-entry queue; holds off the caller while the queue is full.
// ----------------------------------------------------------------------------
module tdd_front import tdd_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic start,
	input  wire  cmd_t cmd,
	output logic       busy,
	output logic       q_valid,
	output cmd_t       q_cmd,
	input  wire  logic q_pop
);
	cmd_t       buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/tdd_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdd_engine: launch tables and dependency walk
// Executes one command at a time against the launch, edge and ready tables
// and emits one result word per command.
// ----------------------------------------------------------------------------
module tdd_engine import tdd_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic q_valid,
	input  wire  cmd_t q_cmd,
	output logic       q_pop,
	output logic       rsp_valid,
	output rsp_t       rsp
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_WRD  = 3'd4;
	localparam logic [2:0] S_WEX  = 3'd5;

	logic [TASK_BITS-1:0] total_mem  [LAUNCHES];
	logic [TASK_BITS-1:0] nidx_mem   [LAUNCHES];
	logic [TASK_BITS-1:0] fin_mem    [LAUNCHES];
	logic [OPEN_W-1:0]    open_mem   [LAUNCHES];
	logic                 done_mem   [LAUNCHES];
	logic [ELNK_W-1:0]    head_mem   [LAUNCHES];
	logic [ELNK_W-1:0]    tail_mem   [LAUNCHES];
	logic [LID_W-1:0]     etgt_mem   [EDGES];
	logic [ELNK_W-1:0]    elnk_mem   [EDGES];
	logic [LID_W-1:0]     rdy_mem    [LAUNCHES];

	logic [2:0]           state_q;
	cmd_t                 cmd_q;
	logic [ELNK_W-1:0]    edges_q;
	logic [LID_W-1:0]     rhead_q, rtail_q;
	logic [LCNT_W-1:0]    rcount_q, next_q, run_q;
	logic [OPEN_W-1:0]    pend_q;
	logic [LID_W-1:0]     id_q;
	logic [ELNK_W-1:0]    e_q;
	logic [LID_W-1:0]     tgt_q;

	logic [TASK_BITS-1:0] total_r, nidx_r, fin_r;
	logic [OPEN_W-1:0]    open_r;
	logic                 done_r;
	logic [ELNK_W-1:0]    head_r, tail_r;
	logic [LID_W-1:0]     rdy_r;
	logic [LID_W-1:0]     etgt_r;
	logic [ELNK_W-1:0]    elnk_r;

	logic [LID_W-1:0]     rd_addr;
	logic [TASK_BITS-1:0] tcount;
	logic [TASK_BITS:0]   idx_inc;
	logic                 idle_now;
	logic                 walk_go;
	rsp_t                 exec_rsp, walk_rsp;

	assign tcount  = cmd_q.task_count[TASK_BITS-1:0];
	assign idx_inc = {1'b0, nidx_r} + 1'b1;
	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign walk_go = (cmd_q.operation == OP_FINISH) &&
		(9'(cmd_q.finished_launch) < 9'(next_q)) && !done_r && (fin_r < nidx_r) &&
		(fin_r + 1'b1 == total_r);

	always_comb begin
		case (cmd_q.operation)
			OP_SUBMIT: rd_addr = cmd_q.dependency_id[LID_W-1:0];
			OP_FETCH:  rd_addr = rdy_r;
			default:   rd_addr = cmd_q.finished_launch[LID_W-1:0];
		endcase
	end

	// registered read of the ready queue front, which addresses the table reads of a fetch
	always_ff @(posedge clk) begin
		rdy_r <= rdy_mem[rhead_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD || state_q == S_WRD) begin
			total_r <= total_mem[state_q == S_WRD ? tgt_q : rd_addr];
			nidx_r  <= nidx_mem[rd_addr];
			fin_r   <= fin_mem[rd_addr];
			open_r  <= open_mem[state_q == S_WRD ? tgt_q : rd_addr];
			done_r  <= done_mem[rd_addr];
			head_r  <= head_mem[rd_addr];
			tail_r  <= tail_mem[rd_addr];
		end
		if (state_q == S_WALK) begin
			etgt_r <= etgt_mem[e_q[EID_W-1:0] - 1'b1];
			elnk_r <= elnk_mem[e_q[EID_W-1:0] - 1'b1];
		end
	end

	always_comb begin
		exec_rsp = '0;
		exec_rsp.status = ST_REFUSED;
		case (cmd_q.operation)
			OP_SUBMIT: begin
				if (next_q < LCNT_W'(LAUNCHES) && tcount != '0 &&
					!(cmd_q.has_dependency &&
					({1'b0, cmd_q.dependency_id} >= 9'(next_q) ||
					(!done_r && (edges_q >= ELNK_W'(EDGES) ||
					pend_q >= OPEN_MAX))))) begin
					exec_rsp.launch_id = 8'(next_q);
					exec_rsp.status = cmd_q.last_of_submission ? ST_CREATED : ST_TAKEN;
				end
			end
			OP_FETCH: begin
				if (rcount_q == '0) begin
					exec_rsp.status = ST_NONE;
				end else if (LCNT_W'(rdy_r) < next_q && nidx_r < total_r) begin
					exec_rsp.status = ST_ISSUED;
					exec_rsp.launch_id = 8'(rdy_r);
					exec_rsp.task_index = 16'(nidx_r);
					exec_rsp.launch_task_count = 16'(total_r);
				end
			end
			OP_FINISH: begin
				if (9'(cmd_q.finished_launch) < 9'(next_q) && !done_r &&
					fin_r < nidx_r) begin
					exec_rsp.launch_id = cmd_q.finished_launch;
					exec_rsp.status = (fin_r + 1'b1 == total_r) ? ST_DONE : ST_COUNTED;
				end
			end
			default: ;
		endcase
		exec_rsp.all_idle = idle_now;
	end

	always_comb begin
		walk_rsp = rsp;
		walk_rsp.all_idle = idle_now;
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else begin
			case (state_q)
				S_EXEC: begin
					rsp       <= exec_rsp;
					rsp_valid <= !walk_go;
				end
				S_WALK: begin
					rsp       <= walk_rsp;
					rsp_valid <= (e_q == '0);
				end
				default: rsp_valid <= 1'b0;
			endcase
		end
	end

	// idle flag as seen after this command's effects
	always_comb begin
		logic [LCNT_W-1:0] rc, rn;
		rc = rcount_q;
		rn = run_q;
		if (state_q == S_EXEC) begin
			case (cmd_q.operation)
				OP_SUBMIT:
					if (next_q < LCNT_W'(LAUNCHES) && tcount != '0 &&
						!(cmd_q.has_dependency &&
						({1'b0, cmd_q.dependency_id} >= 9'(next_q) ||
						(!done_r && (edges_q >= ELNK_W'(EDGES) ||
						pend_q >= OPEN_MAX)))) &&
						cmd_q.last_of_submission &&
						(pend_q + ((cmd_q.has_dependency && !done_r) ? 1'b1 : 1'b0))
						== '0 && rcount_q < LCNT_W'(LAUNCHES))
						rc = rcount_q + 1'b1;
				OP_FETCH:
					if (rcount_q != '0 && LCNT_W'(rdy_r) < next_q && nidx_r < total_r &&
						idx_inc == {1'b0, total_r}) begin
						rc = rcount_q - 1'b1;
						rn = run_q + 1'b1;
					end
				default: ;
			endcase
		end
		idle_now = (rn == '0) && (rc == '0);
	end

	// table and state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			edges_q  <= '0;
			rhead_q  <= '0;
			rtail_q  <= '0;
			rcount_q <= '0;
			next_q   <= '0;
			run_q    <= '0;
			pend_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (q_valid) state_q <= S_RD;
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= walk_go ? S_WALK : S_IDLE;
					case (cmd_q.operation)
						OP_SUBMIT: begin
							if (next_q < LCNT_W'(LAUNCHES) && tcount != '0 &&
								!(cmd_q.has_dependency &&
								({1'b0, cmd_q.dependency_id} >= 9'(next_q) ||
								(!done_r && (edges_q >= ELNK_W'(EDGES) ||
								pend_q >= OPEN_MAX))))) begin
								logic [OPEN_W-1:0] po;
								po = pend_q;
								if (cmd_q.has_dependency && !done_r) begin
									edges_q <= edges_q + 1'b1;
									po = pend_q + 1'b1;
								end
								pend_q <= cmd_q.last_of_submission ? '0 : po;
								if (cmd_q.last_of_submission) begin
									next_q <= next_q + 1'b1;
									if (po == '0 && rcount_q < LCNT_W'(LAUNCHES)) begin
										rtail_q  <= rtail_q + 1'b1;
										rcount_q <= rcount_q + 1'b1;
									end
								end
							end
						end
						OP_FETCH: begin
							if (rcount_q != '0 && LCNT_W'(rdy_r) < next_q &&
								nidx_r < total_r && idx_inc == {1'b0, total_r}) begin
								rhead_q  <= rhead_q + 1'b1;
								rcount_q <= rcount_q - 1'b1;
								run_q    <= run_q + 1'b1;
							end
						end
						OP_FINISH: begin
							if (walk_go) begin
								if (run_q != '0) run_q <= run_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				S_WALK: state_q <= (e_q == '0) ? S_IDLE : S_WRD;
				S_WRD: state_q <= S_WEX;
				S_WEX: begin
					state_q <= S_WALK;
					if (LCNT_W'(tgt_q) >= next_q) begin
						if (pend_q != '0) pend_q <= pend_q - 1'b1;
					end else if (open_r != '0 && open_r == OPEN_W'(1) &&
						rcount_q < LCNT_W'(LAUNCHES)) begin
						rtail_q  <= rtail_q + 1'b1;
						rcount_q <= rcount_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers and table writes
	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
		// clear the list of the launch being built and the link of the next edge
		if (state_q == S_RD && cmd_q.operation == OP_SUBMIT) begin
			if (next_q < LCNT_W'(LAUNCHES)) begin
				head_mem[next_q[LID_W-1:0]] <= '0;
				tail_mem[next_q[LID_W-1:0]] <= '0;
			end
			if (edges_q < ELNK_W'(EDGES))
				elnk_mem[edges_q[EID_W-1:0]] <= '0;
		end
		if (state_q == S_EXEC) begin
			case (cmd_q.operation)
				OP_SUBMIT: begin
					if (next_q < LCNT_W'(LAUNCHES) && tcount != '0 &&
						!(cmd_q.has_dependency &&
						({1'b0, cmd_q.dependency_id} >= 9'(next_q) ||
						(!done_r && (edges_q >= ELNK_W'(EDGES) ||
						pend_q >= OPEN_MAX))))) begin
						logic [OPEN_W-1:0] po;
						logic [LID_W-1:0]  nid;
						po  = pend_q;
						nid = next_q[LID_W-1:0];
						if (cmd_q.has_dependency && !done_r) begin
							etgt_mem[edges_q[EID_W-1:0]] <= nid;
							if (head_r == '0)
								head_mem[rd_addr] <= edges_q + 1'b1;
							else
								elnk_mem[tail_r[EID_W-1:0] - 1'b1] <= edges_q + 1'b1;
							tail_mem[rd_addr] <= edges_q + 1'b1;
							po = pend_q + 1'b1;
						end
						if (cmd_q.last_of_submission) begin
							total_mem[nid] <= tcount;
							nidx_mem[nid]  <= '0;
							fin_mem[nid]   <= '0;
							open_mem[nid]  <= po;
							done_mem[nid]  <= 1'b0;
							if (po == '0 && rcount_q < LCNT_W'(LAUNCHES))
								rdy_mem[rtail_q] <= nid;
						end
					end
				end
				OP_FETCH:
					if (rcount_q != '0 && LCNT_W'(rdy_r) < next_q && nidx_r < total_r)
						nidx_mem[rdy_r] <= idx_inc[TASK_BITS-1:0];
				OP_FINISH:
					if (9'(cmd_q.finished_launch) < 9'(next_q) && !done_r &&
						fin_r < nidx_r) begin
						fin_mem[rd_addr] <= fin_r + 1'b1;
						if (fin_r + 1'b1 == total_r) begin
							done_mem[rd_addr] <= 1'b1;
							e_q <= head_r;
						end
					end
				default: ;
			endcase
		end
		if (state_q == S_WRD) tgt_q <= etgt_r;
		if (state_q == S_WALK && e_q != '0) begin
			tgt_q <= etgt_mem[e_q[EID_W-1:0] - 1'b1];
		end
		if (state_q == S_WRD) e_q <= elnk_r;
		if (state_q == S_WEX && LCNT_W'(tgt_q) < next_q && open_r != '0) begin
			open_mem[tgt_q] <= open_r - 1'b1;
			if (open_r == OPEN_W'(1) && rcount_q < LCNT_W'(LAUNCHES))
				rdy_mem[rtail_q] <= tgt_q;
		end
	end
endmodule
`default_nettype wire

// ===== src/task_dependency_dispatcher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// task_dependency_dispatcher_unit: dependency-counting task dispatcher
// Accepts submit, fetch and finish commands and answers each with one word.
//
//   channel   | handshake             | word
//   command   | start / busy          | cmd   (cmd_t)
//   result    | done strobe, no stall | rsp   (rsp_t)
//
// An accepted word passes the queue and the engine's read and execute states
// before its result is registered; a finish that completes a launch also walks
// each dependent edge. The engine takes no new word until done with the last.
// A two-word queue sits between intake and engine; busy rises only while it is
// full. Reset clears counters and pointers; tables are written before use.
// ----------------------------------------------------------------------------
module task_dependency_dispatcher_unit import tdd_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic start,
	input  wire  cmd_t cmd,
	output logic       busy,
	output logic       done,
	output rsp_t       rsp
);
	logic q_valid, q_pop;
	cmd_t q_cmd;

	tdd_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	tdd_engine u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd),
		.q_pop(q_pop), .rsp_valid(done), .rsp(rsp)
	);
endmodule
`default_nettype wire
